### rtl/rotation_matrix_to_quaternion_defines.svh
// Assertion macros for the rotation matrix to quaternion pipeline.
// Included by rotation_matrix_to_quaternion.sv; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmq assertion failed");
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmq assertion failed");
`else
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rmq_pkg.sv
// Constants and types for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;
	localparam int FRAC_BITS = 16;
	localparam int W_IO      = 18;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int THRESH    = (ONE + 50000) / 100000;
	localparam int OUT_MAX   = 131071;
	localparam int OUT_MIN   = -131072;
	localparam int NUM_W     = 20;               // numerators after column flip
	localparam int RAD_W     = 36;               // radicand << FRAC_BITS, even width
	localparam int SQ_N      = RAD_W / 2;        // root bits, one per stage
	localparam int SQ_REM_W  = SQ_N + 2;
	localparam int DVD_W     = 36;               // |n| << FRAC_BITS plus rounding
	localparam int DV_N      = DVD_W;            // quotient bits, one per stage
	localparam int S_W       = SQ_N + 1;         // s = 2 * root
	localparam int QW        = DVD_W + 2;        // signed lane result before clamp

	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

	typedef struct packed {
		branch_t                  br;
		logic signed [NUM_W-1:0]  n0;
		logic signed [NUM_W-1:0]  n1;
		logic signed [NUM_W-1:0]  n2;
	} ctx_t;
endpackage

### rtl/rotation_matrix_to_quaternion.sv
// Takes one request per cycle while the result is not held by out_ready low.
// Stages: determinant with column flip, branch select, 18 square root steps,
// one divider setup, 36 divider steps (three lanes), 2 for sign and clamp.
// Whole pipeline stalls together when the result is held by out_ready low.
// Reset (arst_n low, asynchronous) clears only the stage valid bits.
`include "rotation_matrix_to_quaternion_defines.svh"
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [W_IO-1:0]  read_x,
	input  logic signed [W_IO-1:0]  read_y,
	input  logic signed [W_IO-1:0]  read_z,
	input  logic signed [W_IO-1:0]  phase_x,
	input  logic signed [W_IO-1:0]  phase_y,
	input  logic signed [W_IO-1:0]  phase_z,
	input  logic signed [W_IO-1:0]  slice_x,
	input  logic signed [W_IO-1:0]  slice_y,
	input  logic signed [W_IO-1:0]  slice_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [W_IO-1:0]  quat_first,
	output logic signed [W_IO-1:0]  quat_second,
	output logic signed [W_IO-1:0]  quat_third,
	output logic signed [W_IO-1:0]  quat_fourth
);
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	assign en       = !vld_s8 || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// ---- stage 1: cofactor products
	logic signed [W_IO-1:0] r11_s1, r21_s1, r31_s1, r12_s1, r22_s1, r32_s1;
	logic signed [W_IO-1:0] r13_s1, r23_s1, r33_s1;
	logic signed [2*W_IO-1:0] pa_s1, pb_s1, pc_s1, pd_s1, pe_s1, pf_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			r11_s1 <= read_x;  r21_s1 <= read_y;  r31_s1 <= read_z;
			r12_s1 <= phase_x; r22_s1 <= phase_y; r32_s1 <= phase_z;
			r13_s1 <= slice_x; r23_s1 <= slice_y; r33_s1 <= slice_z;
			pa_s1 <= phase_y * slice_z;
			pb_s1 <= slice_y * phase_z;
			pc_s1 <= read_y * slice_z;
			pd_s1 <= slice_y * read_z;
			pe_s1 <= read_y * phase_z;
			pf_s1 <= phase_y * read_z;
		end
	end

	// ---- stage 2: cofactors
	logic signed [W_IO-1:0] r11_s2, r21_s2, r31_s2, r12_s2, r22_s2, r32_s2;
	logic signed [W_IO-1:0] r13_s2, r23_s2, r33_s2;
	logic signed [2*W_IO:0] c1_s2, c2_s2, c3_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			r11_s2 <= r11_s1; r21_s2 <= r21_s1; r31_s2 <= r31_s1;
			r12_s2 <= r12_s1; r22_s2 <= r22_s1; r32_s2 <= r32_s1;
			r13_s2 <= r13_s1; r23_s2 <= r23_s1; r33_s2 <= r33_s1;
			c1_s2 <= (2*W_IO+1)'(pa_s1) - (2*W_IO+1)'(pb_s1);
			c2_s2 <= (2*W_IO+1)'(pc_s1) - (2*W_IO+1)'(pd_s1);
			c3_s2 <= (2*W_IO+1)'(pe_s1) - (2*W_IO+1)'(pf_s1);
		end
	end

	// ---- stage 3: first-row terms of the determinant
	logic signed [W_IO-1:0] r11_s3, r21_s3, r31_s3, r12_s3, r22_s3, r32_s3;
	logic signed [W_IO-1:0] r13_s3, r23_s3, r33_s3;
	logic signed [3*W_IO:0] m1_s3, m2_s3, m3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			r11_s3 <= r11_s2; r21_s3 <= r21_s2; r31_s3 <= r31_s2;
			r12_s3 <= r12_s2; r22_s3 <= r22_s2; r32_s3 <= r32_s2;
			r13_s3 <= r13_s2; r23_s3 <= r23_s2; r33_s3 <= r33_s2;
			m1_s3 <= r11_s2 * c1_s2;
			m2_s3 <= r12_s2 * c2_s2;
			m3_s3 <= r13_s2 * c3_s2;
		end
	end

	// ---- stage 4: determinant sign, flip third column
	logic signed [3*W_IO+2:0] det_c;
	logic signed [W_IO-1:0]   r11_s4, r21_s4, r31_s4, r12_s4, r22_s4, r32_s4;
	logic signed [W_IO:0]     r13_s4, r23_s4, r33_s4;

	assign det_c = (3*W_IO+3)'(m1_s3) - (3*W_IO+3)'(m2_s3) + (3*W_IO+3)'(m3_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			r11_s4 <= r11_s3; r21_s4 <= r21_s3; r31_s4 <= r31_s3;
			r12_s4 <= r12_s3; r22_s4 <= r22_s3; r32_s4 <= r32_s3;
			if (det_c[3*W_IO+2]) begin
				r13_s4 <= -(W_IO+1)'(r13_s3);
				r23_s4 <= -(W_IO+1)'(r23_s3);
				r33_s4 <= -(W_IO+1)'(r33_s3);
			end else begin
				r13_s4 <= (W_IO+1)'(r13_s3);
				r23_s4 <= (W_IO+1)'(r23_s3);
				r33_s4 <= (W_IO+1)'(r33_s3);
			end
		end
	end

	// ---- stage 5: branch select, radicand and numerators
	logic signed [W_IO+2:0] t_c, xd_c, yd_c, zd_c, rad_c;
	ctx_t                   ctx_c;
	ctx_t                   ctx_s5;
	logic [W_IO:0]          rad_s5;

	always_comb begin
		t_c  = (W_IO+3)'(ONE) + (W_IO+3)'(r11_s4) + (W_IO+3)'(r22_s4) + (W_IO+3)'(r33_s4);
		xd_c = (W_IO+3)'(ONE) + (W_IO+3)'(r11_s4) - (W_IO+3)'(r22_s4) - (W_IO+3)'(r33_s4);
		yd_c = (W_IO+3)'(ONE) + (W_IO+3)'(r22_s4) - (W_IO+3)'(r11_s4) - (W_IO+3)'(r33_s4);
		zd_c = (W_IO+3)'(ONE) + (W_IO+3)'(r33_s4) - (W_IO+3)'(r11_s4) - (W_IO+3)'(r22_s4);
		if (t_c > (W_IO+3)'(THRESH)) begin
			ctx_c.br = BR_TRACE;
			rad_c    = t_c;
			ctx_c.n0 = NUM_W'(r32_s4) - NUM_W'(r23_s4);
			ctx_c.n1 = NUM_W'(r13_s4) - NUM_W'(r31_s4);
			ctx_c.n2 = NUM_W'(r21_s4) - NUM_W'(r12_s4);
		end else if (xd_c > (W_IO+3)'(ONE)) begin
			ctx_c.br = BR_X;
			rad_c    = xd_c;
			ctx_c.n0 = NUM_W'(r21_s4) + NUM_W'(r12_s4);
			ctx_c.n1 = NUM_W'(r31_s4) + NUM_W'(r13_s4);
			ctx_c.n2 = NUM_W'(r32_s4) - NUM_W'(r23_s4);
		end else if (yd_c > (W_IO+3)'(ONE)) begin
			ctx_c.br = BR_Y;
			rad_c    = yd_c;
			ctx_c.n0 = NUM_W'(r21_s4) + NUM_W'(r12_s4);
			ctx_c.n1 = NUM_W'(r32_s4) + NUM_W'(r23_s4);
			ctx_c.n2 = NUM_W'(r13_s4) - NUM_W'(r31_s4);
		end else begin
			ctx_c.br = BR_Z;
			rad_c    = zd_c;
			ctx_c.n0 = NUM_W'(r13_s4) + NUM_W'(r31_s4);
			ctx_c.n1 = NUM_W'(r23_s4) + NUM_W'(r32_s4);
			ctx_c.n2 = NUM_W'(r21_s4) - NUM_W'(r12_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5 <= ctx_c;
			rad_s5 <= (rad_c[W_IO+2] || rad_c == '0) ? '0 : rad_c[W_IO:0];
		end
	end

	// ---- square root, one result bit per stage
	logic                sq_vld  [SQ_N+1];
	ctx_t                sq_ctx  [SQ_N+1];
	logic [RAD_W-1:0]    sq_v    [SQ_N+1];
	logic [SQ_N-1:0]     sq_root [SQ_N+1];
	logic [SQ_REM_W-1:0] sq_rem  [SQ_N+1];

	assign sq_vld[0]  = vld_s5;
	assign sq_ctx[0]  = ctx_s5;
	assign sq_v[0]    = {{(RAD_W-FRAC_BITS-W_IO-1){1'b0}}, rad_s5, {FRAC_BITS{1'b0}}};
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		logic [SQ_REM_W+1:0] rt;
		logic [SQ_REM_W-1:0] tr;
		logic                ge;

		assign rt = {sq_rem[k], sq_v[k][RAD_W-1 -: 2]};
		assign tr = {sq_root[k], 2'b01};
		assign ge = rt >= {2'b00, tr};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_ctx[k+1]  <= sq_ctx[k];
				sq_v[k+1]    <= sq_v[k] << 2;
				sq_root[k+1] <= {sq_root[k][SQ_N-2:0], ge};
				sq_rem[k+1]  <= ge ? SQ_REM_W'(rt - {2'b00, tr}) : SQ_REM_W'(rt);
			end
		end
	end

	// ---- stage 6: divider setup, |n| << FRAC_BITS plus s/2
	logic signed [NUM_W-1:0] nsel [3];
	logic [S_W-1:0]          s_s6;
	logic [SQ_N-1:0]         w_s6;
	branch_t                 br_s6;
	logic [DVD_W-1:0]        dvd_s6 [3];
	logic                    neg_s6 [3];
	logic                    zero_s6 [3];

	assign nsel[0] = sq_ctx[SQ_N].n0;
	assign nsel[1] = sq_ctx[SQ_N].n1;
	assign nsel[2] = sq_ctx[SQ_N].n2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sq_vld[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s6  <= {sq_root[SQ_N], 1'b0};
			w_s6  <= SQ_N'(({1'b0, sq_root[SQ_N]} + (SQ_N+1)'(1)) >> 1);
			br_s6 <= sq_ctx[SQ_N].br;
			for (int l = 0; l < 3; l++) begin
				neg_s6[l]  <= nsel[l][NUM_W-1];
				zero_s6[l] <= nsel[l] == '0;
				dvd_s6[l]  <= {(nsel[l][NUM_W-1] ? NUM_W'(-nsel[l]) : NUM_W'(nsel[l])),
					{FRAC_BITS{1'b0}}} + DVD_W'(sq_root[SQ_N]);
			end
		end
	end

	// ---- restoring divider, three lanes sharing s, one quotient bit per stage
	logic             dv_vld  [DV_N+1];
	logic [S_W-1:0]   dv_s    [DV_N+1];
	logic [SQ_N-1:0]  dv_w    [DV_N+1];
	branch_t          dv_br   [DV_N+1];
	logic [DVD_W-1:0] dv_dvd  [DV_N+1][3];
	logic [S_W-1:0]   dv_rem  [DV_N+1][3];
	logic [DVD_W-1:0] dv_quo  [DV_N+1][3];
	logic             dv_neg  [DV_N+1][3];
	logic             dv_zero [DV_N+1][3];

	assign dv_vld[0] = vld_s6;
	assign dv_s[0]   = s_s6;
	assign dv_w[0]   = w_s6;
	assign dv_br[0]  = br_s6;
	for (genvar l = 0; l < 3; l++) begin : g_dv0
		assign dv_dvd[0][l]  = dvd_s6[l];
		assign dv_rem[0][l]  = '0;
		assign dv_quo[0][l]  = '0;
		assign dv_neg[0][l]  = neg_s6[l];
		assign dv_zero[0][l] = zero_s6[l];
	end

	for (genvar k = 0; k < DV_N; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld[k+1] <= dv_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1]  <= dv_s[k];
				dv_w[k+1]  <= dv_w[k];
				dv_br[k+1] <= dv_br[k];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [S_W:0] tt;
			logic         ge;

			assign tt = {dv_rem[k][l], dv_dvd[k][l][DVD_W-1]};
			assign ge = tt >= {1'b0, dv_s[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					dv_dvd[k+1][l]  <= dv_dvd[k][l] << 1;
					dv_rem[k+1][l]  <= ge ? S_W'(tt - {1'b0, dv_s[k]}) : S_W'(tt);
					dv_quo[k+1][l]  <= {dv_quo[k][l][DVD_W-2:0], ge};
					dv_neg[k+1][l]  <= dv_neg[k][l];
					dv_zero[k+1][l] <= dv_zero[k][l];
				end
			end
		end
	end

	// ---- stage 7: signed lane values, zero-divisor saturation, placement
	logic signed [QW-1:0] lane_c [3];
	logic signed [QW-1:0] q_s7 [4];
	logic                 norm_s7;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (dv_zero[DV_N][l]) begin
				lane_c[l] = '0;
			end else if (dv_s[DV_N] == '0) begin
				lane_c[l] = dv_neg[DV_N][l] ? QW'(OUT_MIN) : QW'(OUT_MAX);
			end else if (dv_neg[DV_N][l]) begin
				lane_c[l] = -$signed({2'b00, dv_quo[DV_N][l]});
			end else begin
				lane_c[l] = $signed({2'b00, dv_quo[DV_N][l]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= dv_vld[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s7 <= dv_br[DV_N] != BR_TRACE;
			unique case (dv_br[DV_N])
				BR_TRACE: begin
					q_s7[0] <= lane_c[0]; q_s7[1] <= lane_c[1];
					q_s7[2] <= lane_c[2]; q_s7[3] <= $signed(QW'(dv_w[DV_N]));
				end
				BR_X: begin
					q_s7[0] <= $signed(QW'(dv_w[DV_N])); q_s7[1] <= lane_c[0];
					q_s7[2] <= lane_c[1]; q_s7[3] <= lane_c[2];
				end
				BR_Y: begin
					q_s7[0] <= lane_c[0]; q_s7[1] <= $signed(QW'(dv_w[DV_N]));
					q_s7[2] <= lane_c[1]; q_s7[3] <= lane_c[2];
				end
				default: begin
					q_s7[0] <= lane_c[0]; q_s7[1] <= lane_c[1];
					q_s7[2] <= $signed(QW'(dv_w[DV_N])); q_s7[3] <= lane_c[2];
				end
			endcase
		end
	end

	// ---- stage 8: sign normalisation and output clamp
	logic                   flip_c;
	logic signed [QW-1:0]   fv_c [4];
	logic signed [W_IO-1:0] q_s8 [4];
	logic                   norm_s8;

	assign flip_c = norm_s7 && q_s7[0][QW-1];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			fv_c[i] = flip_c ? -q_s7[i] : q_s7[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_s8 <= norm_s7;
			for (int i = 0; i < 4; i++) begin
				if (fv_c[i] > QW'(OUT_MAX)) begin
					q_s8[i] <= W_IO'(OUT_MAX);
				end else if (fv_c[i] < QW'(OUT_MIN)) begin
					q_s8[i] <= W_IO'(OUT_MIN);
				end else begin
					q_s8[i] <= fv_c[i][W_IO-1:0];
				end
			end
		end
	end

	assign quat_first  = q_s8[0];
	assign quat_second = q_s8[1];
	assign quat_third  = q_s8[2];
	assign quat_fourth = q_s8[3];

	// remainder of the last square root step never exceeds twice the root
	`RMQ_ASSERT_IMP(a_sq_rem, clk, arst_n, sq_vld[SQ_N], sq_rem[SQ_N] <= {1'b0, sq_root[SQ_N], 1'b0})
	// divider remainders stay below the divisor
	`RMQ_ASSERT_IMP(a_dv_rem, clk, arst_n, dv_vld[DV_N] && dv_s[DV_N] != '0, (dv_rem[DV_N][0] < dv_s[DV_N]) && (dv_rem[DV_N][1] < dv_s[DV_N]) && (dv_rem[DV_N][2] < dv_s[DV_N]))
	`RMQ_ASSERT_NXT(a_out_load, clk, arst_n, vld_s7 && en, out_valid)
	// off-trace branches leave a non-negative first component
	`RMQ_ASSERT_IMP(a_norm, clk, arst_n, out_valid && norm_s8, !quat_first[W_IO-1])
endmodule

### test/rotation_matrix_to_quaternion_tb.sv
// Self-checking bench for the rotation matrix to quaternion pipeline.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; the quaternion predictor is built in.
module rotation_matrix_to_quaternion_tb import rmq_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [W_IO-1:0] fx_t;
	typedef struct {
		fx_t m [9];
	} matrix_t;
	typedef struct {
		fx_t q [4];
	} quat_t;

	localparam int LATENCY = 62;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fx_t read_x = '0, read_y = '0, read_z = '0;
	fx_t phase_x = '0, phase_y = '0, phase_z = '0;
	fx_t slice_x = '0, slice_y = '0, slice_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fx_t quat_first, quat_second, quat_third, quat_fourth;

	matrix_t pending_requests [$];
	quat_t expected_quats [$];
	int mismatches = 0;
	int results_seen = 0;
	int trace_cases = 0;
	int diag_cases = 0;
	bit stimulus_done = 1'b0;

	rotation_matrix_to_quaternion DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.read_x(read_x), .read_y(read_y), .read_z(read_z),
		.phase_x(phase_x), .phase_y(phase_y), .phase_z(phase_z),
		.slice_x(slice_x), .slice_y(slice_y), .slice_z(slice_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_first(quat_first), .quat_second(quat_second),
		.quat_third(quat_third), .quat_fourth(quat_fourth)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint root_twice(longint x);
		longint v, r, b;
		if (x <= 0) return 0;
		v = x <<< FRAC_BITS;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return 2 * r;
	endfunction

	function automatic longint round_div(longint n, longint s);
		longint mag;
		if (n == 0) return 0;
		if (s <= 0) return (n > 0) ? longint'(OUT_MAX) : longint'(OUT_MIN);
		mag = (n < 0) ? -n : n;
		mag = ((mag <<< FRAC_BITS) + s / 2) / s;
		return (n < 0) ? -mag : mag;
	endfunction

	function automatic quat_t matrix_to_quat(matrix_t a);
		longint r11, r21, r31, r12, r22, r32, r13, r23, r33;
		longint det, t, s, xd, yd, zd;
		longint q [4];
		quat_t res;
		r11 = longint'(a.m[0]); r21 = longint'(a.m[1]); r31 = longint'(a.m[2]);
		r12 = longint'(a.m[3]); r22 = longint'(a.m[4]); r32 = longint'(a.m[5]);
		r13 = longint'(a.m[6]); r23 = longint'(a.m[7]); r33 = longint'(a.m[8]);
		det = r11*r22*r33 + r12*r23*r31 + r21*r32*r13
			- r13*r22*r31 - r12*r21*r33 - r11*r23*r32;
		if (det < 0) begin
			r13 = -r13; r23 = -r23; r33 = -r33;
		end
		t = ONE + r11 + r22 + r33;
		if (t > THRESH) begin
			trace_cases++;
			s = root_twice(t);
			q[0] = round_div(r32 - r23, s);
			q[1] = round_div(r13 - r31, s);
			q[2] = round_div(r21 - r12, s);
			q[3] = (s + 2) >>> 2;
		end else begin
			diag_cases++;
			xd = ONE + r11 - (r22 + r33);
			yd = ONE + r22 - (r11 + r33);
			zd = ONE + r33 - (r11 + r22);
			if (xd > ONE) begin
				s = root_twice(xd);
				q[0] = (s + 2) >>> 2;
				q[1] = round_div(r21 + r12, s);
				q[2] = round_div(r31 + r13, s);
				q[3] = round_div(r32 - r23, s);
			end else if (yd > ONE) begin
				s = root_twice(yd);
				q[0] = round_div(r21 + r12, s);
				q[1] = (s + 2) >>> 2;
				q[2] = round_div(r32 + r23, s);
				q[3] = round_div(r13 - r31, s);
			end else begin
				s = root_twice(zd);
				q[0] = round_div(r13 + r31, s);
				q[1] = round_div(r23 + r32, s);
				q[2] = (s + 2) >>> 2;
				q[3] = round_div(r21 - r12, s);
			end
			if (q[0] < 0)
				for (int k = 0; k < 4; k++) q[k] = -q[k];
		end
		for (int k = 0; k < 4; k++) begin
			if (q[k] > OUT_MAX) q[k] = OUT_MAX;
			if (q[k] < OUT_MIN) q[k] = OUT_MIN;
			res.q[k] = fx_t'(q[k]);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, fx_t got, fx_t want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic fx_t rand_field();
		case ($urandom_range(0, 9))
			0: return fx_t'(ONE);
			1: return fx_t'(-ONE);
			2: return fx_t'(0);
			3: return fx_t'($urandom);
			default: return fx_t'($signed($urandom_range(0, 2*ONE)) - ONE);
		endcase
	endfunction

	function automatic matrix_t mat(int a0, int a1, int a2, int a3, int a4,
			int a5, int a6, int a7, int a8);
		matrix_t r;
		r.m[0] = fx_t'(a0); r.m[1] = fx_t'(a1); r.m[2] = fx_t'(a2);
		r.m[3] = fx_t'(a3); r.m[4] = fx_t'(a4); r.m[5] = fx_t'(a5);
		r.m[6] = fx_t'(a6); r.m[7] = fx_t'(a7); r.m[8] = fx_t'(a8);
		return r;
	endfunction

	// a proper rotation about one axis by a quantised angle, optionally reflected
	function automatic matrix_t rand_rotation();
		matrix_t r;
		real ang, c, s;
		int ci, si, ax;
		ang = ($urandom_range(0, 3600) / 3600.0) * 6.283185307;
		c = $cos(ang); s = $sin(ang);
		ci = $rtoi(c * ONE); si = $rtoi(s * ONE);
		ax = $urandom_range(0, 2);
		if (ax == 0) r = mat(ONE, 0, 0, 0, ci, si, 0, -si, ci);
		else if (ax == 1) r = mat(ci, 0, -si, 0, ONE, 0, si, 0, ci);
		else r = mat(ci, si, 0, -si, ci, 0, 0, 0, ONE);
		if ($urandom_range(0, 3) == 0)
			for (int k = 6; k < 9; k++) r.m[k] = -r.m[k];
		return r;
	endfunction

	initial begin
		matrix_t r;
		// identity, half turns about each axis (diagonal branches), reflection, zero matrix
		pending_requests.push_back(mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
		pending_requests.push_back(mat(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
		pending_requests.push_back(mat(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
		pending_requests.push_back(mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
		pending_requests.push_back(mat(ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
		pending_requests.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// trace just below, right at and just above threshold
		pending_requests.push_back(mat(-ONE/2, 0, 0, 0, -ONE/2, 0, 0, 0, 0));
		pending_requests.push_back(mat(-ONE/2, 0, 0, 0, -ONE/2, 0, 0, 0, 1));
		pending_requests.push_back(mat(-ONE/2, 0, 0, 0, -ONE/2, 0, 0, 0, 2));
		// reflected matrices with non-zero numerators: one on the trace branch, one on the z branch
		pending_requests.push_back(mat(0, ONE, ONE, -ONE, 0, ONE, ONE, ONE, -ONE));
		pending_requests.push_back(mat(-ONE, -ONE, 0, ONE, -ONE, 0, 0, 0, -ONE));
		// extremes of the field range
		pending_requests.push_back(mat(131071, 131071, 131071, 131071, 131071,
			131071, 131071, 131071, 131071));
		pending_requests.push_back(mat(-131072, -131072, -131072, -131072,
			-131072, -131072, -131072, -131072, -131072));
		pending_requests.push_back(mat(131071, -131072, 131071, -131072, 131071,
			-131072, 131071, -131072, 131071));
		pending_requests.push_back(mat(-131072, 131071, 0, 131071, -131072, 0,
			0, 0, -131072));
		for (int i = 0; i < 450; i++) begin
			if ($urandom_range(0, 3) != 0) begin
				r = rand_rotation();
			end else begin
				for (int k = 0; k < 9; k++) r.m[k] = rand_field();
			end
			pending_requests.push_back(r);
		end
	end

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
				expected_quats.push_back(matrix_to_quat('{m: '{read_x, read_y, read_z,
					phase_x, phase_y, phase_z, slice_x, slice_y, slice_z}}));
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0 && !(in_valid && in_ready)) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if ((in_gap == 0 || (in_valid && in_ready)) &&
						pending_requests.size() > 0 &&
						!(in_valid && in_ready && in_gap != 0)) begin
					in_valid <= 1'b1;
					{read_x, read_y, read_z} <= {pending_requests[0].m[0],
						pending_requests[0].m[1], pending_requests[0].m[2]};
					{phase_x, phase_y, phase_z} <= {pending_requests[0].m[3],
						pending_requests[0].m[4], pending_requests[0].m[5]};
					{slice_x, slice_y, slice_z} <= {pending_requests[0].m[6],
						pending_requests[0].m[7], pending_requests[0].m[8]};
					void'(pending_requests.pop_front());
				end else begin
					in_valid <= 1'b0;
					if (pending_requests.size() == 0 && !in_valid) stimulus_done <= 1'b1;
				end
			end
		end
	end

	// monitor
	int out_wait = 0;
	always @(posedge clk) begin
		quat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_quats.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					mismatches++;
				end else begin
					want = expected_quats.pop_front();
					if (quat_first !== want.q[0]) report_mismatch("first", quat_first, want.q[0]);
					if (quat_second !== want.q[1])
						report_mismatch("second", quat_second, want.q[1]);
					if (quat_third !== want.q[2]) report_mismatch("third", quat_third, want.q[2]);
					if (quat_fourth !== want.q[3])
						report_mismatch("fourth", quat_fourth, want.q[3]);
				end
			end
			if (out_valid && out_ready || out_wait == 0) begin
				out_wait <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
				out_ready <= ($urandom_range(0, 2) == 0) || out_wait == 0;
			end else begin
				out_wait <= out_wait - 1;
				out_ready <= 1'b0;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done && expected_quats.size() == 0);
		repeat (LATENCY * 3) @(posedge clk);
		$display("checked %0d quaternions: %0d via trace, %0d via diagonal branches",
			results_seen, trace_cases, diag_cases);
		if (mismatches == 0 && expected_quats.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end
endmodule
